@@ hdl/b64d_pkg.sv @@
// Package: shared types, constants and the character map of the base64 decoder.
`default_nettype none
package b64d_pkg;

    localparam logic [6:0] SEXTET_BAD = 7'd77;
    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_SHORT = 2'd1,
        ST_BAD_CHAR  = 2'd2,
        ST_BAD_LEN   = 2'd3
    } status_t;

    // One queue entry: what a single character leaves for the back end.
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic       has_status;
        status_t    status;
    } entry_t;

    // Map a character to its sextet, SEXTET_BAD when outside the alphabet.
    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [6:0] s;
        s = SEXTET_BAD;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s = 7'd62;
        end else if (c == 8'h2F) begin
            s = 7'd63;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

@@ hdl/b64d_front.sv @@
// Front end: accept characters, track group state, build queue entries.
`default_nettype none
module b64d_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [7:0]      s_char_in,
    input  wire logic            s_is_last,
    input  wire logic            q_full,
    output logic                 q_push,
    output b64d_pkg::entry_t     q_entry
);
    import b64d_pkg::*;

    logic [5:0] prev_sextet_reg, prev_sextet_next;
    logic [1:0] group_pos_reg, group_pos_next;
    logic       pad_seen_reg, pad_seen_next;
    logic       bad_seen_reg, bad_seen_next;
    logic [2:0] total_count_reg, total_count_next;
    logic [6:0] sextet;
    logic       accept;
    entry_t     entry;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign sextet  = map_char(s_char_in);

    always_comb begin
        prev_sextet_next = prev_sextet_reg;
        group_pos_next   = group_pos_reg;
        pad_seen_next    = pad_seen_reg;
        bad_seen_next    = bad_seen_reg;
        total_count_next = (total_count_reg < 3'd4) ? total_count_reg + 3'd1 : total_count_reg;
        entry            = '0;

        if (!pad_seen_reg && !bad_seen_reg) begin
            if (s_char_in == PAD_CHAR) begin
                pad_seen_next = 1'b1;
            end else if (sextet == SEXTET_BAD) begin
                bad_seen_next = 1'b1;
            end else begin
                unique case (group_pos_reg)
                    2'd1: begin
                        entry.has_byte = 1'b1;
                        entry.data     = {prev_sextet_reg, sextet[5:4]};
                    end
                    2'd2: begin
                        entry.has_byte = 1'b1;
                        entry.data     = {prev_sextet_reg[3:0], sextet[5:2]};
                    end
                    2'd3: begin
                        entry.has_byte = 1'b1;
                        entry.data     = {prev_sextet_reg[1:0], sextet[5:0]};
                    end
                    default: begin
                        entry.has_byte = 1'b0;
                    end
                endcase
                prev_sextet_next = sextet[5:0];
                group_pos_next   = group_pos_reg + 2'd1;
            end
        end

        if (s_is_last) begin
            entry.has_status = 1'b1;
            priority if (total_count_next < 3'd4) begin
                entry.status = ST_TOO_SHORT;
            end else if (bad_seen_next) begin
                entry.status = ST_BAD_CHAR;
            end else if (group_pos_next == 2'd1) begin
                entry.status = ST_BAD_LEN;
            end else begin
                entry.status = ST_OK;
            end
        end
    end

    assign q_push  = accept && (entry.has_byte || entry.has_status);
    assign q_entry = entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sextet_reg <= '0;
            group_pos_reg   <= '0;
            pad_seen_reg    <= 1'b0;
            bad_seen_reg    <= 1'b0;
            total_count_reg <= '0;
        end else if (accept) begin
            if (s_is_last) begin
                // run closes: return to the start state
                prev_sextet_reg <= '0;
                group_pos_reg   <= '0;
                pad_seen_reg    <= 1'b0;
                bad_seen_reg    <= 1'b0;
                total_count_reg <= '0;
            end else begin
                prev_sextet_reg <= prev_sextet_next;
                group_pos_reg   <= group_pos_next;
                pad_seen_reg    <= pad_seen_next;
                bad_seen_reg    <= bad_seen_next;
                total_count_reg <= total_count_next;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/b64d_fifo.sv @@
// Short queue of entries between the front end and the back end.
`default_nettype none
module b64d_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire b64d_pkg::entry_t push_entry,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output b64d_pkg::entry_t      head
);
    import b64d_pkg::*;

    entry_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/b64d_back.sv @@
// Back end: unpack queue entries into result words through an output register.
`default_nettype none
module b64d_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_not_empty,
    input  wire b64d_pkg::entry_t q_head,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_end_of_run,
    output logic [1:0]            m_status
);
    import b64d_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       eor_reg;
    logic [1:0] status_reg;
    logic       byte_done_reg, byte_done_next;
    logic       load;
    logic       send_byte;

    assign load      = (!valid_reg || m_ready) && q_not_empty;
    assign send_byte = q_head.has_byte && !byte_done_reg;

    always_comb begin
        q_pop          = 1'b0;
        byte_done_next = byte_done_reg;
        if (load) begin
            if (send_byte && q_head.has_status) begin
                // hold the entry: its status word follows
                byte_done_next = 1'b1;
            end else begin
                q_pop          = 1'b1;
                byte_done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (send_byte) begin
                byte_reg   <= q_head.data;
                eor_reg    <= 1'b0;
                status_reg <= ST_OK;
            end else begin
                byte_reg   <= '0;
                eor_reg    <= 1'b1;
                status_reg <= q_head.status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            byte_done_reg <= 1'b0;
        end else begin
            byte_done_reg <= byte_done_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_end_of_run = eor_reg;
    assign m_status     = status_reg;

endmodule
`default_nettype wire

@@ hdl/base64_decoder_checked_core.sv @@
// Top level of the streaming base64 decoder with run status.
//
// Input channel (s_): one base64 character word per handshake; s_is_last
// marks the final character of a run. Standard alphabet, no line breaks.
// Output channel (m_): one result word per handshake. A data word carries a
// decoded byte with m_end_of_run low and m_status zero; the closing word of a
// run has m_end_of_run high, m_out_byte zero and m_status set to
// 0 ok, 1 too short, 2 invalid character, 3 bad length.
// Throughput: one character per cycle while the queue has room. A character
// that both completes a byte and ends the run gives two words, sent one after
// the other from the output register; a four-entry queue between decode and
// output takes up the slack. A character's entry is written into the queue,
// then loaded into the output register that drives m_.
// The output register and the queue hold results while m_ready is low; once
// the queue fills, s_ready drops until words drain.
// Reset (aresetn low, synchronous) empties the queue, drops m_valid and
// returns the decoder to the start of a run. Each run also ends in that state.
`default_nettype none
module base64_decoder_checked_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    input  wire logic       s_is_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_end_of_run,
    output logic [1:0]      m_status
);
    import b64d_pkg::*;

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_not_empty;
    entry_t q_entry;
    entry_t q_head;

    // decode characters and build entries
    b64d_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_char_in (s_char_in),
        .s_is_last (s_is_last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // decouple decode from output stalls
    b64d_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // advance entries into result words
    b64d_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_end_of_run (m_end_of_run),
        .m_status     (m_status)
    );

endmodule
`default_nettype wire

@@ hdl/b64d_checker.sv @@
// Port-level checker for the base64 decoder, bound to the top level.
`default_nettype none
module b64d_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_end_of_run,
    input wire logic [1:0] m_status
);
    import b64d_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_end_of_run) && $stable(m_status))
        else $error("stalled word changed");

    a_data_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_end_of_run |-> m_status == ST_OK)
        else $error("data word carries a status");

    a_status_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_run |-> m_out_byte == 8'h00)
        else $error("status word carries a byte");

endmodule

bind base64_decoder_checked_core b64d_checker u_b64d_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_byte   (m_out_byte),
    .m_end_of_run (m_end_of_run),
    .m_status     (m_status)
);
`default_nettype wire

@@ bench/b64d_result_checker.sv @@
// Checker for the base64 decoder: predicts the words of each character and compares them.
`timescale 1ns / 100ps
module b64d_result_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [7:0] s_char_in,
    input  wire logic       s_is_last,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [7:0] m_out_byte,
    input  wire logic       m_end_of_run,
    input  wire logic [1:0] m_status,
    output int              failures,
    output int              pending
);
    import b64d_pkg::*;

    // A run shorter than this many characters closes as too short.
    localparam logic [2:0] FULL_COUNT = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       closing;
        status_t    st;
    } word_t;

    word_t      expected_words[$];
    logic [5:0] prev_sextet;
    logic [1:0] group_pos;
    logic       pad_seen;
    logic       bad_seen;
    logic [2:0] char_count;
    int         mismatches = 0;

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return 7'(c - "A");
        if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
        if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
        if (c == "+") return 7'd62;
        if (c == "/") return 7'd63;
        return SEXTET_BAD;
    endfunction

    task automatic clear_run();
        prev_sextet = '0;
        group_pos   = '0;
        pad_seen    = 1'b0;
        bad_seen    = 1'b0;
        char_count  = '0;
    endtask

    // Advance the decoder image by one character and queue the words it yields.
    task automatic decode_char(input logic [7:0] c, input logic last);
        logic [6:0] s;
        word_t      w;
        status_t    st;
        if (char_count < FULL_COUNT) char_count++;
        if (!pad_seen && !bad_seen) begin
            if (c == PAD_CHAR) begin
                pad_seen = 1'b1;
            end else begin
                s = sextet_of(c);
                if (s == SEXTET_BAD) begin
                    bad_seen = 1'b1;
                end else begin
                    if (group_pos != 2'd0) begin
                        case (group_pos)
                            2'd1: w.data = {prev_sextet, s[5:4]};
                            2'd2: w.data = {prev_sextet[3:0], s[5:2]};
                            default: w.data = {prev_sextet[1:0], s[5:0]};
                        endcase
                        w.closing = 1'b0;
                        w.st      = ST_OK;
                        expected_words.push_back(w);
                    end
                    prev_sextet = s[5:0];
                    group_pos++;
                end
            end
        end
        if (last) begin
            if (char_count < FULL_COUNT) st = ST_TOO_SHORT;
            else if (bad_seen)           st = ST_BAD_CHAR;
            else if (group_pos == 2'd1)  st = ST_BAD_LEN;
            else                         st = ST_OK;
            w = '{data: 8'h00, closing: 1'b1, st: st};
            expected_words.push_back(w);
            clear_run();
        end
    endtask

    always @(posedge aclk) begin : watch
        word_t want;
        if (!aresetn) begin
            clear_run();
            expected_words.delete();
        end else begin
            // A word leaving now cannot stem from a character entering now.
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, %s %02h end %0b status %0d",
                             $time, "got byte", m_out_byte, m_end_of_run, m_status);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_out_byte !== want.data) begin
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.data, m_out_byte);
                        mismatches++;
                    end
                    if (m_end_of_run !== want.closing) begin
                        $display("%0t: end_of_run expected %0b, got %0b",
                                 $time, want.closing, m_end_of_run);
                        mismatches++;
                    end
                    if (m_status !== want.st) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.st, m_status);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) decode_char(s_char_in, s_is_last);
        end
        failures <= mismatches;
        pending  <= expected_words.size();
    end

endmodule

@@ bench/tb.sv @@
// Testbench top: drives character runs into the base64 decoder and reports the verdict.
`timescale 1ns / 100ps
module tb;
    import b64d_pkg::*;

    localparam int unsigned CLK_PERIOD   = 12;
    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned TARGET_CHARS = 1350;
    localparam int unsigned DRAIN_CYCLES = 8;
    // Far beyond the slowest legal run: ~1400 words, at most two results each, stalls on both sides.
    localparam int unsigned LIMIT_CYCLES = 400_000;
    // Idle or stall about 22 percent of the time.
    localparam int unsigned IDLE_PCT     = 22;
    // Window of the random part that runs with no idling at all.
    localparam int unsigned CALM_FROM    = 500;
    localparam int unsigned CALM_TO      = 800;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_in;
    logic       s_is_last;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_end_of_run;
    logic [1:0] m_status;

    int         failures;
    int         pending;
    int         chars_sent = 0;
    logic       calm = 1'b0;
    logic [7:0] run_buf[$];

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    base64_decoder_checked_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_in    (s_char_in),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_end_of_run (m_end_of_run),
        .m_status     (m_status)
    );

    b64d_result_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_in    (s_char_in),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_end_of_run (m_end_of_run),
        .m_status     (m_status),
        .failures     (failures),
        .pending      (pending)
    );

    // Stall the result channel at random, except inside the calm window.
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Hold each word until the handshake; drop valid only on an idle cycle.
    task automatic send_word(input logic [7:0] c, input logic last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= c;
        s_is_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Send the buffered run, flagging its final character as the end.
    task automatic flush_run();
        foreach (run_buf[i]) send_word(run_buf[i], i == run_buf.size() - 1);
        chars_sent += run_buf.size();
        run_buf.delete();
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) run_buf.push_back(txt[i]);
        flush_run();
    endtask

    function automatic logic [7:0] alphabet_char(input logic [5:0] s);
        if (s < 26) return 8'("A" + s);
        if (s < 52) return 8'("a" + s - 26);
        if (s < 62) return 8'("0" + s - 52);
        return (s == 6'd62) ? 8'("+") : 8'("/");
    endfunction

    // Pick a byte that is neither in the alphabet nor the pad.
    function automatic logic [7:0] junk_char();
        case ($urandom_range(5))
            0: return 8'($urandom_range(8'h00, 8'h2A));
            1: return 8'($urandom_range(8'h2C, 8'h2E));
            2: return 8'($urandom_range(8'h3A, 8'h3C));
            3: return 8'($urandom_range(8'h3E, 8'h40));
            4: return 8'($urandom_range(8'h5B, 8'h60));
            default: return 8'($urandom_range(8'h7B, 8'hFF));
        endcase
    endfunction

    // Fill run_buf with whole groups; the last may carry one or two pads.
    task automatic build_groups(input int groups);
        int pads;
        pads = $urandom_range(2);
        for (int i = 0; i < groups * 4; i++) run_buf.push_back(alphabet_char(6'($urandom)));
        for (int i = 0; i < pads; i++) run_buf[run_buf.size() - 1 - i] = PAD_CHAR;
        // Anything after a pad is ignored; throw some in now and then.
        if (pads != 0 && $urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) run_buf.push_back(8'($urandom));
        end
    endtask

    task automatic random_run();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 62) begin
            // Well-formed text, mostly short, now and then long.
            build_groups(($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4));
        end else if (pick < 78) begin
            // Valid characters at any length, so every group position ends a run.
            len = $urandom_range(1, 13);
            repeat (len) run_buf.push_back(alphabet_char(6'($urandom)));
            if ($urandom_range(2) == 0) run_buf.push_back(PAD_CHAR);
        end else if (pick < 90) begin
            // Well-formed text with one character spoiled.
            build_groups($urandom_range(1, 3));
            run_buf[$urandom_range(run_buf.size() - 1)] = junk_char();
        end else begin
            // Raw noise over the full byte range.
            len = $urandom_range(1, 10);
            repeat (len) run_buf.push_back(8'($urandom));
        end
        flush_run();
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_char_in <= 8'h00;
        s_is_last <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed runs: a full group, all-ones and pad, a lone character,
        // invalid bytes at both ends of the range, a dangling sextet,
        // and a pad right at the start with junk behind it.
        send_text("TWFu");
        send_text("//+=");
        send_text("Q");
        run_buf = '{"a", "b", 8'h00, 8'hFF};
        flush_run();
        send_text("09AZa");
        send_text("=z=!");

        while (chars_sent < TARGET_CHARS) begin
            calm = (chars_sent >= CALM_FROM && chars_sent < CALM_TO);
            random_run();
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // Let the last pushes land in the checker, then drain.
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ base64_decoder_checked_core.f @@
hdl/b64d_pkg.sv
hdl/b64d_front.sv
hdl/b64d_fifo.sv
hdl/b64d_back.sv
hdl/base64_decoder_checked_core.sv
hdl/b64d_checker.sv
bench/b64d_result_checker.sv
bench/tb.sv
